FILE: rtl/scrl_pkg.sv
// scrl_pkg: shared constants and codes for the scrollback line ring append core
// no dependencies; imported by rtl/scrollback_line_ring_append_core.sv
package scrl_pkg;

	// default geometry of the ring
	localparam int unsigned HistoryLinesDef = 256;
	localparam int unsigned LineCharsDef    = 160;

	// operation carried in the input beat's tuser
	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// console bytes with special handling
	localparam logic [7:0] ChCr       = 8'h0D;
	localparam logic [7:0] ChLf       = 8'h0A;
	localparam logic [7:0] ChTab      = 8'h09;
	localparam logic [7:0] ChSpace    = 8'h20;
	localparam logic [7:0] ChTilde    = 8'h7E;
	localparam logic [7:0] ChQuestion = 8'h3F;

	// index of the last space record of a tab; a tab expands to four spaces
	localparam logic [1:0] TabLastRep = 2'd3;

	// packed stream widths
	localparam int unsigned STdataW = 8;
	localparam int unsigned STuserW = 2;
	localparam int unsigned MTdataW = 48;
	localparam int unsigned MTuserW = 4;

endpackage

FILE: rtl/scrollback_line_ring_append_core.sv
// scrollback_line_ring_append_core: console bytes into a ring of history lines,
// one character write record per result beat; depends on rtl/scrl_pkg.sv
//
//  channel  dir  handshake            tdata                         tuser / tlast
//  s_*      in   s_tvalid / s_tready  char_code                     opcode, from_error_stream
//  m_*      out  m_tvalid / m_tready  slot, col, char, oldest, held flags; tlast = last record
//
// a beat waits in the input stage, then its record goes to the output
// register; a printable byte, newline or clear leaves with one record, so one beat per cycle
// while the output is not stalled; a tab stays in the input stage until all four of its space
// records have gone; carriage return leaves the input stage without a record
// the output register refills in the cycle m_tready takes its beat, so a stalled
// output only holds the input stage; reset (arst_n low) empties both and the ring
module scrollback_line_ring_append_core
	import scrl_pkg::*;
#(
	parameter int unsigned HISTORY_LINES = HistoryLinesDef,
	parameter int unsigned LINE_CHARS    = LineCharsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [STdataW-1:0] s_tdata,   // [7:0] char_code
	input  logic [STuserW-1:0] s_tuser,   // [0] opcode, [1] from_error_stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [MTdataW-1:0] m_tdata,   // [7:0] line_slot, [15:8] column, [23:16] char_out,
	                                      // [31:24] oldest_slot_out, [40:32] lines_held_out
	output logic [MTuserW-1:0] m_tuser,   // [0] write_valid, [1] line_error_stream,
	                                      // [2] line_started, [3] cleared
	output logic               m_tlast
);

	localparam int unsigned SW = $clog2(HISTORY_LINES);
	localparam int unsigned HW = $clog2(HISTORY_LINES + 1);
	localparam int unsigned LW = $clog2(LINE_CHARS);
	localparam logic [SW-1:0] SlotMax = SW'(HISTORY_LINES - 1);
	localparam logic [HW-1:0] HeldMax = HW'(HISTORY_LINES);
	localparam logic [LW-1:0] LenMax  = LW'(LINE_CHARS - 1);

	// input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] char_s1;
	logic       err_s1;
	logic [1:0] rep_s1;   // spaces already sent for a tab

	// ring state
	logic [SW-1:0] oldest_q;
	logic [SW-1:0] newest_q;
	logic [HW-1:0] held_q;
	logic          open_q;
	logic [LW-1:0] len_q;
	logic          stream_q;

	// output register
	logic       out_valid_q;
	logic [7:0] slot_out_q;
	logic [7:0] col_out_q;
	logic [7:0] char_out_q;
	logic [7:0] oldest_out_q;
	logic [8:0] held_out_q;
	logic       wv_q, es_q, started_q, clr_q, last_q;

	// decode
	logic       is_clear, is_cr, is_lf, is_tab;
	logic [7:0] char_sub;
	logic       produce, out_free, step_ok, done;

	// next state for one record
	logic          ens_start, start;
	logic [SW-1:0] oldest_n, newest_n;
	logic [HW-1:0] held_n;
	logic          open_n, stream_n;
	logic [LW-1:0] len_n, col_n;
	logic          rec_wv, rec_last;
	logic [7:0]    rec_char;

	// wide-to-field helpers: zero extend, then take the low field bits
	logic [SW+7:0] slot_ext, oldest_ext;
	logic [LW+7:0] col_ext;
	logic [HW+8:0] held_ext;

	always_comb begin
		is_clear = (op_s1 == OP_CLEAR);
		is_cr    = !is_clear && (char_s1 == ChCr);
		is_lf    = !is_clear && (char_s1 == ChLf);
		is_tab   = !is_clear && (char_s1 == ChTab);
		if (is_tab) begin
			char_sub = ChSpace;
		end else if (char_s1 inside {[ChSpace:ChTilde]}) begin
			char_sub = char_s1;
		end else begin
			char_sub = ChQuestion;
		end
		produce  = !is_cr;
		out_free = !out_valid_q || m_tready;
		step_ok  = valid_s1 && (!produce || out_free);
		done     = step_ok && (!is_tab || rep_s1 == TabLastRep);
		s_tready = !valid_s1 || done;
	end

	always_comb begin
		// a line opens when none is, or the stream changes on a non-empty line;
		// a full line also opens a fresh one for a character
		ens_start = (held_q == '0) || !open_q || ((stream_q != err_s1) && (len_q != '0));
		start     = ens_start || (!is_lf && (len_q >= LenMax));

		oldest_n = oldest_q;
		newest_n = newest_q;
		held_n   = held_q;
		len_n    = len_q;
		col_n    = len_q;
		if (start) begin
			newest_n = (newest_q == SlotMax) ? '0 : newest_q + 1'b1;
			col_n    = '0;
			if (held_q >= HeldMax) begin
				// ring full: oldest line goes
				oldest_n = (oldest_q == SlotMax) ? '0 : oldest_q + 1'b1;
			end else begin
				held_n = held_q + 1'b1;
			end
		end
		stream_n = err_s1;
		rec_last = !is_tab || (rep_s1 == TabLastRep);

		if (is_clear) begin
			oldest_n = '0;
			newest_n = SlotMax;
			held_n   = '0;
			open_n   = 1'b0;
			len_n    = '0;
			stream_n = 1'b0;
			rec_wv   = 1'b0;
			rec_char = '0;
			col_n    = '0;
		end else if (is_lf) begin
			open_n   = 1'b0;
			len_n    = start ? '0 : len_q;
			rec_wv   = 1'b0;
			rec_char = '0;
			col_n    = '0;
		end else begin
			open_n   = 1'b1;
			len_n    = col_n + 1'b1;
			rec_wv   = 1'b1;
			rec_char = char_sub;
		end

		slot_ext   = {8'b0, newest_n};
		oldest_ext = {8'b0, oldest_n};
		col_ext    = {8'b0, col_n};
		held_ext   = {9'b0, held_n};
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rep_s1   <= '0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
			rep_s1   <= '0;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end else if (step_ok) begin
			rep_s1 <= rep_s1 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser[0]);
			err_s1  <= s_tuser[1];
			char_s1 <= s_tdata;
		end
	end

	// ring state moves once per record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			newest_q <= SlotMax;
			held_q   <= '0;
			open_q   <= 1'b0;
			len_q    <= '0;
			stream_q <= 1'b0;
		end else if (step_ok && produce) begin
			oldest_q <= oldest_n;
			newest_q <= newest_n;
			held_q   <= held_n;
			open_q   <= open_n;
			len_q    <= len_n;
			stream_q <= stream_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_ok && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_ok && produce) begin
			slot_out_q   <= is_clear ? 8'b0 : slot_ext[7:0];
			col_out_q    <= col_ext[7:0];
			char_out_q   <= rec_char;
			oldest_out_q <= oldest_ext[7:0];
			held_out_q   <= held_ext[8:0];
			wv_q         <= rec_wv;
			es_q         <= stream_n;
			started_q    <= start && !is_clear;
			clr_q        <= is_clear;
			last_q       <= rec_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, held_out_q, oldest_out_q, char_out_q, col_out_q, slot_out_q};
	assign m_tuser  = {clr_q, started_q, es_q, wv_q};
	assign m_tlast  = last_q;

	// a clear record reports an empty ring
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tdata[40:32] == 9'd0)
		else $error("clear record with lines held");

	// a character on a freshly started line lands in the first column
	a_start_col0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tuser[2] |-> m_tdata[15:8] == 8'd0)
		else $error("started line written past column zero");

	// line count never passes the ring depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HeldMax)
		else $error("lines held beyond ring depth");

	// input stalls only behind a busy input stage
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && !done)
		else $error("input stalled with stage free");

endmodule

FILE: bench/tb_scrollback_line_ring_append_core.sv
// tb_scrollback_line_ring_append_core: self-checking bench for the scrollback line ring core
// predicts every write record from the console beats it sends and checks each output beat
// depends on rtl/scrl_pkg.sv and rtl/scrollback_line_ring_append_core.sv
`timescale 1ns / 100ps

module tb_scrollback_line_ring_append_core;
	import scrl_pkg::*;

	localparam int unsigned HISTORY_LINES = HistoryLinesDef;
	localparam int unsigned LINE_CHARS    = LineCharsDef;
	// cycles with no beat moving on either side before the run is abandoned
	localparam int unsigned QUIET_LIMIT   = 2000;
	// cycles left after the last record to catch anything stray
	localparam int unsigned TAIL_CYCLES   = 16;

	// one write record as it should appear on the master side
	typedef struct packed {
		logic       write_valid;
		logic [7:0] line_slot;
		logic [7:0] column;
		logic [7:0] char_out;
		logic       line_error_stream;
		logic       line_started;
		logic       cleared;
		logic [7:0] oldest_slot_out;
		logic [8:0] lines_held_out;
		logic       last;
	} ring_record_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [STdataW-1:0] s_tdata;
	logic [STuserW-1:0] s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [MTdataW-1:0] m_tdata;
	logic [MTuserW-1:0] m_tuser;
	logic               m_tlast;

	// records still owed by the core, oldest first
	ring_record_t expected_records[$];
	int unsigned  error_count;
	int unsigned  quiet_cycles;
	bit           idle_bursts_on;
	int unsigned  stall_left;

	// predicted history state, kept at full width
	int unsigned  hist_oldest;
	int unsigned  hist_held;
	bit           line_is_open;
	int unsigned  line_len;
	bit           line_stream;
	int unsigned  lines_dropped;
	bit           cur_stream;

	scrollback_line_ring_append_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void ring_clear();
		hist_oldest  = 0;
		hist_held    = 0;
		line_is_open = 1'b0;
		line_len     = 0;
		line_stream  = 1'b0;
	endfunction

	// a new line drops the oldest one once the ring is full
	function automatic void ring_start_line(bit s);
		if (hist_held >= HISTORY_LINES) begin
			hist_oldest = (hist_oldest + 1) % HISTORY_LINES;
			hist_held   = HISTORY_LINES - 1;
			lines_dropped++;
		end
		hist_held++;
		line_is_open = 1'b1;
		line_len     = 0;
		line_stream  = s;
	endfunction

	// returns 1 when a fresh line had to be started
	function automatic bit ring_ensure_line(bit s);
		if (hist_held == 0 || !line_is_open) begin
			ring_start_line(s);
			return 1'b1;
		end
		// stream change on a line that already holds text
		if (line_stream != s && line_len != 0) begin
			ring_start_line(s);
			return 1'b1;
		end
		line_stream = s;
		return 1'b0;
	endfunction

	function automatic int unsigned ring_newest();
		return (hist_oldest + hist_held - 1) % HISTORY_LINES;
	endfunction

	// snapshot of the record, taken after the state update it belongs to
	function automatic ring_record_t ring_record(bit wv, int unsigned slot, int unsigned col,
			logic [7:0] ch, bit es, bit started, bit clr);
		ring_record_t r;
		r.write_valid       = wv;
		r.line_slot         = slot[7:0];
		r.column            = col[7:0];
		r.char_out          = ch;
		r.line_error_stream = es;
		r.line_started      = started;
		r.cleared           = clr;
		r.oldest_slot_out   = hist_oldest[7:0];
		r.lines_held_out    = hist_held[8:0];
		r.last              = 1'b0;
		return r;
	endfunction

	function automatic ring_record_t ring_put_char(logic [7:0] ch, bit s);
		bit          started;
		int unsigned col;
		started = ring_ensure_line(s);
		// full line: close it and carry on in a new one
		if (line_len + 1 >= LINE_CHARS) begin
			line_is_open = 1'b0;
			ring_start_line(s);
			started = 1'b1;
		end
		col = line_len;
		line_len++;
		return ring_record(1'b1, ring_newest(), col, ch, s, started, 1'b0);
	endfunction

	// works out the records that one accepted console beat must produce
	function automatic void ring_apply_beat(op_t op, logic [7:0] ch, bit es);
		ring_record_t recs[$];
		bit           started;
		logic [7:0]   shown;
		if (op == OP_CLEAR) begin
			ring_clear();
			recs.push_back(ring_record(1'b0, 0, 0, 8'h00, 1'b0, 1'b0, 1'b1));
		end else if (ch == ChCr) begin
			// carriage return vanishes without a record
		end else if (ch == ChLf) begin
			started      = ring_ensure_line(es);
			line_is_open = 1'b0;
			recs.push_back(ring_record(1'b0, ring_newest(), 0, 8'h00, line_stream,
				started, 1'b0));
		end else if (ch == ChTab) begin
			repeat (int'(TabLastRep) + 1)
				recs.push_back(ring_put_char(ChSpace, es));
		end else begin
			shown = (ch < ChSpace || ch > ChTilde) ? ChQuestion : ch;
			recs.push_back(ring_put_char(shown, es));
		end
		if (recs.size() > 0)
			recs[recs.size() - 1].last = 1'b1;
		foreach (recs[i])
			expected_records.push_back(recs[i]);
	endfunction

	// ---------------------------------------------------------------- slave side driver

	// one console beat; held until the core takes it, gaps drawn beforehand
	task automatic send_console_beat(op_t op, logic [7:0] ch, bit es);
		int unsigned gap;
		if (idle_bursts_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= {es, logic'(op)};
		do @(posedge clk); while (!s_tready);
		ring_apply_beat(op, ch, es);
	endtask

	// random beat; the stream flips now and then so stream changes stay common
	task automatic send_random_beat(bit with_clear);
		int unsigned pick;
		logic [7:0]  ch;
		op_t         op;
		pick = $urandom_range(0, 99);
		op   = OP_APPEND;
		if ($urandom_range(0, 4) == 0)
			cur_stream = ~cur_stream;
		if (with_clear && pick < 4) begin
			op = OP_CLEAR;
			ch = $urandom_range(0, 255);
		end else if (pick < 20) begin
			ch = ChLf;
		end else if (pick < 30) begin
			ch = ChTab;
		end else if (pick < 35) begin
			ch = ChCr;
		end else if (pick < 55) begin
			ch = $urandom_range(0, 255);
		end else begin
			ch = $urandom_range(ChSpace, ChTilde);
		end
		send_console_beat(op, ch, cur_stream);
	endtask

	// sender holds off until every owed record has come back
	task automatic wait_all_records();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_records.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	// field extremes, every byte class and both operations
	task automatic test_directed();
		send_console_beat(OP_APPEND, "A", 1'b0);
		send_console_beat(OP_APPEND, ChSpace, 1'b0);
		send_console_beat(OP_APPEND, ChTilde, 1'b0);
		send_console_beat(OP_APPEND, 8'h1F, 1'b0);  // just below printable
		send_console_beat(OP_APPEND, 8'h7F, 1'b0);  // just above printable
		send_console_beat(OP_APPEND, 8'h00, 1'b0);
		send_console_beat(OP_APPEND, 8'hFF, 1'b0);
		send_console_beat(OP_APPEND, ChCr, 1'b0);
		send_console_beat(OP_APPEND, ChTab, 1'b0);
		send_console_beat(OP_APPEND, "x", 1'b1);    // stream change on a line with text
		send_console_beat(OP_APPEND, ChLf, 1'b1);   // closes the open line
		send_console_beat(OP_APPEND, ChLf, 1'b0);   // no open line: empty line started and closed
		send_console_beat(OP_APPEND, "b", 1'b0);
		send_console_beat(OP_APPEND, ChLf, 1'b1);   // newline on the other stream
		send_console_beat(OP_APPEND, ChTab, 1'b1);  // tab opening a line
		send_console_beat(OP_APPEND, ChCr, 1'b1);
		send_console_beat(OP_CLEAR, "Z", 1'b0);
		send_console_beat(OP_APPEND, ChLf, 1'b0);   // newline on an empty history
		send_console_beat(OP_CLEAR, ChCr, 1'b0);    // clear wins over the byte
		send_console_beat(OP_CLEAR, ChLf, 1'b1);
		send_console_beat(OP_APPEND, 8'h80, 1'b1);
		send_console_beat(OP_APPEND, "!", 1'b0);
	endtask

	// line length limit: once on a plain byte, once on the last space of a tab
	task automatic test_line_wrap();
		send_console_beat(OP_APPEND, ChLf, 1'b0);
		send_console_beat(OP_APPEND, "L", 1'b0);
		repeat (39) send_console_beat(OP_APPEND, ChTab, 1'b0);
		send_console_beat(OP_APPEND, "m", 1'b0);
		send_console_beat(OP_APPEND, "n", 1'b0);    // last column of the line
		send_console_beat(OP_APPEND, "o", 1'b0);    // spills into a new line
		send_console_beat(OP_APPEND, ChLf, 1'b0);
		repeat (40) send_console_beat(OP_APPEND, ChTab, 1'b1);
		send_console_beat(OP_APPEND, ChLf, 1'b1);
		wait_all_records();
	endtask

	// almost all newlines so the ring fills and then drops its oldest line a few times
	task automatic test_ring_wrap();
		int unsigned sent;
		sent = 0;
		while (lines_dropped < 4 && sent < 800) begin
			if ($urandom_range(0, 99) < 95)
				send_console_beat(OP_APPEND, ChLf, 1'(($urandom_range(0, 1))));
			else
				send_random_beat(1'b0);
			sent++;
		end
		wait_all_records();
	endtask

	task automatic test_random_mix(int unsigned count);
		repeat (count) send_random_beat(1'b1);
	endtask

	// ---------------------------------------------------------------- master side

	// random stall bursts while idling is on
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			if (error_count < 40)
				$display("%0t %s: expected %0d, got %0d", $time, what, want, got);
			error_count++;
		end
	endtask

	// each output beat against the oldest owed record
	always @(posedge clk) begin
		ring_record_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_records.size() == 0) begin
				if (error_count < 40)
					$display("%0t unexpected record: expected none, got tdata %h tuser %h",
						$time, m_tdata, m_tuser);
				error_count++;
			end else begin
				want = expected_records.pop_front();
				check_field("write_valid", want.write_valid, m_tuser[0]);
				check_field("line_error_stream", want.line_error_stream, m_tuser[1]);
				check_field("line_started", want.line_started, m_tuser[2]);
				check_field("cleared", want.cleared, m_tuser[3]);
				check_field("line_slot", want.line_slot, m_tdata[7:0]);
				check_field("column", want.column, m_tdata[15:8]);
				check_field("char_out", want.char_out, m_tdata[23:16]);
				check_field("oldest_slot_out", want.oldest_slot_out, m_tdata[31:24]);
				check_field("lines_held_out", want.lines_held_out, m_tdata[40:32]);
				check_field("tdata padding", 0, m_tdata[MTdataW-1:41]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// watchdog on cycles where no beat moves
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("scrollback_line_ring_append_core: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		m_tready       = 1'b0;
		error_count    = 0;
		quiet_cycles   = 0;
		stall_left     = 0;
		idle_bursts_on = 1'b0;
		lines_dropped  = 0;
		cur_stream     = 1'b0;
		ring_clear();

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		idle_bursts_on = 1'b1;
		test_line_wrap();
		test_ring_wrap();
		test_random_mix(14);
		// closing stretch runs flat out on both sides
		idle_bursts_on = 1'b0;
		test_random_mix(10);

		wait_all_records();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("scrollback_line_ring_append_core: match");
		else
			$display("scrollback_line_ring_append_core: mismatch");
		$finish;
	end

endmodule
